/* sv/btk_pkg.sv */
// ----------------------------------------------------------------------------
// Blob top-k selector package
// Shared constants, types and state encodings for the selector.
// ----------------------------------------------------------------------------
package btk_pkg;

    localparam int MAX_PARTICLES = 16;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int AREA_W        = 21;
    localparam int MOM_W         = 30;
    localparam int PER_W         = 24;
    localparam int Q_W           = 16;
    localparam int LIM_W         = 5;
    localparam int ROI_W         = 11;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 21;

    // Divider widths: numerator and denominator 64 bits, quotient kept to 48 bits.
    localparam int NUM_W         = 64;
    localparam int DEN_W         = 64;
    localparam int QUO_W         = 48;
    localparam int QUO_CNT_W     = $clog2(QUO_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_Y    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_DIVX,
        ST_DIVY,
        ST_DIVC_MUL,
        ST_DIVC,
        ST_SHIFT,
        ST_WRITE,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y,
        DIV_C
    } div_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;        // capture input item
        logic       chk_full;    // evaluate filter and full test
        logic       pos_clr;     // reset search pointer
        logic       pos_inc;     // advance search pointer
        logic       div_start;   // launch a divide
        div_sel_t   div_sel;     // which quotient
        logic       mul_step;    // load shift pointer from n
        logic       shift_step;  // move one entry down
        logic       write_ent;   // write new entry at pos
        logic       emit_clr;    // reset emit pointer
        logic       emit_step;   // emit one entry
        logic       emit_empty;  // emit empty-frame word
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       is_eof;
        logic       keep;        // passes filter and fits or beats the tail
        logic       search_done;
        logic       div_done;
        logic       shift_done;
        logic       list_empty;
        logic       emit_last;
    } dp_sts_t;

endpackage

/* sv/btk_ctrl.sv */
// ----------------------------------------------------------------------------
// Blob top-k controller
// Sequences filtering, sorted search, divisions, insertion and emission.
// ----------------------------------------------------------------------------
module btk_ctrl
    import btk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.is_eof)
                begin
                    state_next = sts.list_empty ? ST_EMPTY : ST_EMIT;
                end
                else if (sts.keep)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (sts.search_done)
                begin
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_DIVC_MUL;
                end
            end
            ST_DIVC_MUL:
            begin
                state_next = ST_DIVC;
            end
            ST_DIVC:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.div_sel = DIV_X;
        busy     = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load    = start;
                cmd.pos_clr = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.chk_full = 1'b1;
                cmd.emit_clr = 1'b1;
            end
            ST_SEARCH:
            begin
                cmd.pos_inc = ~sts.search_done;
                if (sts.search_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_X;
                end
            end
            ST_DIVX:
            begin
                cmd.div_sel = DIV_X;
                if (sts.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_Y;
                end
            end
            ST_DIVY:
            begin
                cmd.div_sel = DIV_Y;
            end
            ST_DIVC_MUL:
            begin
                cmd.mul_step  = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_C;
            end
            ST_DIVC:
            begin
                cmd.div_sel = DIV_C;
            end
            ST_SHIFT:
            begin
                cmd.shift_step = ~sts.shift_done;
            end
            ST_WRITE:
            begin
                cmd.write_ent = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
            end
            ST_EMPTY:
            begin
                cmd.emit_empty = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_emit_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ($past(state_reg) == ST_CHECK || $past(state_reg) == ST_EMIT))
        else $error("emit entered from wrong state");
    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_ent |=> (state_reg == ST_IDLE))
        else $error("write not followed by idle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy)
        else $error("load while busy");
`endif

endmodule

/* sv/btk_dp.sv */
// ----------------------------------------------------------------------------
// Blob top-k datapath
// Holds the sorted list, configuration, a serial divider and result words.
// ----------------------------------------------------------------------------
module btk_dp
    import btk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  action,
    input  logic [AREA_W-1:0]     blob_area,
    input  logic [MOM_W-1:0]      moment_x,
    input  logic [MOM_W-1:0]      moment_y,
    input  logic [PER_W-1:0]      perimeter_q4,
    output logic                  strobe,
    output logic                  valid_res,
    output logic [AREA_W-1:0]     area_out,
    output logic [Q_W-1:0]        centroid_x_q4,
    output logic [Q_W-1:0]        centroid_y_q4,
    output logic [Q_W-1:0]        compactness_q12,
    output logic                  last
);

    // Configuration registers
    logic [AREA_W-1:0] area_min_reg;
    logic [AREA_W-1:0] area_max_reg;
    logic [LIM_W-1:0]  keep_lim_reg;
    logic [ROI_W-1:0]  roi_x_reg;
    logic [ROI_W-1:0]  roi_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_min_reg <= '0;
            area_max_reg <= AREA_W'(1048576);
            keep_lim_reg <= LIM_W'(16);
            roi_x_reg    <= '0;
            roi_y_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_AREA_MIN: area_min_reg <= cfg_data;
                REG_AREA_MAX: area_max_reg <= cfg_data;
                REG_KEEP_LIM: keep_lim_reg <= cfg_data[LIM_W-1:0];
                REG_ROI_X:    roi_x_reg    <= cfg_data[ROI_W-1:0];
                REG_ROI_Y:    roi_y_reg    <= cfg_data[ROI_W-1:0];
                default:      ;
            endcase
        end
    end

    // Captured item
    logic              eof_reg;
    logic [AREA_W-1:0] a_reg;
    logic [MOM_W-1:0]  mx_reg;
    logic [MOM_W-1:0]  my_reg;
    logic [PER_W-1:0]  per_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            eof_reg <= action;
            a_reg   <= blob_area;
            mx_reg  <= moment_x;
            my_reg  <= moment_y;
            per_reg <= perimeter_q4;
        end
    end

    // List storage, one register row per entry
    logic [AREA_W-1:0] kept_area [MAX_PARTICLES];
    logic [Q_W-1:0]    kept_x    [MAX_PARTICLES];
    logic [Q_W-1:0]    kept_y    [MAX_PARTICLES];
    logic [Q_W-1:0]    kept_shape[MAX_PARTICLES];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  n_reg;      // entries kept after drop
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  sh_reg;     // shift pointer, walks down from n

    // Clamp limit
    logic [CNT_W-1:0] limit;
    always_comb
    begin
        if (keep_lim_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if ({{(CNT_W > LIM_W ? CNT_W - LIM_W : 1){1'b0}}, keep_lim_reg} > (CNT_W + 1)'(MAX_PARTICLES))
        begin
            limit = CNT_W'(MAX_PARTICLES);
        end
        else
        begin
            limit = CNT_W'(keep_lim_reg);
        end
    end

    logic [IDX_W-1:0]  tail_idx;
    logic              full;
    logic              in_range;
    logic [IDX_W-1:0]  pos_idx;
    logic [IDX_W-1:0]  sh_idx;

    assign tail_idx = IDX_W'(count_reg - CNT_W'(1));
    assign full     = (count_reg >= limit);
    assign in_range = (a_reg >= area_min_reg) && (a_reg <= area_max_reg);
    assign pos_idx  = pos_reg[IDX_W-1:0];
    assign sh_idx   = sh_reg[IDX_W-1:0];

    // Filter and full test: hold the entry count left after a drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
        end
        else if (cmd.chk_full)
        begin
            n_reg    <= full ? count_reg - CNT_W'(1) : count_reg;
        end
    end

    assign sts.is_eof     = eof_reg;
    assign sts.keep       = in_range && (!full || (a_reg > kept_area[tail_idx]));
    assign sts.list_empty = (count_reg == '0);
    assign sts.search_done = (pos_reg >= n_reg) || !(a_reg < kept_area[pos_idx]);
    assign sts.shift_done  = (sh_reg <= pos_reg);

    // Search pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.pos_clr)
        begin
            pos_reg <= '0;
        end
        else if (cmd.pos_inc)
        begin
            pos_reg <= pos_reg + CNT_W'(1);
        end
    end

    // Perimeter square, registered
    logic [2*PER_W-1:0] psq_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.chk_full)
        begin
            psq_reg <= per_reg * per_reg;
        end
    end

    // Serial restoring divider, one quotient bit per cycle
    logic [NUM_W-1:0]     dnum_reg;
    logic [DEN_W-1:0]     dden_reg;
    logic [NUM_W-1:0]     drem_reg;
    logic [QUO_W-1:0]     dquo_reg;
    logic [QUO_CNT_W-1:0] dcnt_reg;
    logic                 dbusy_reg;
    div_sel_t             dsel_reg;
    logic [NUM_W-1:0]     num_sel;
    logic [DEN_W-1:0]     den_sel;
    logic [NUM_W-1:0]     rem_sh;

    // Operand selection
    always_comb
    begin
        case (cmd.div_sel)
            DIV_X:
            begin
                num_sel = NUM_W'({mx_reg, 4'b0000});
                den_sel = DEN_W'(a_reg);
            end
            DIV_Y:
            begin
                num_sel = NUM_W'({my_reg, 4'b0000});
                den_sel = DEN_W'(a_reg);
            end
            default:
            begin
                // 1256*A*2^20 / (100*P^2), den built from the squared perimeter
                num_sel = NUM_W'(a_reg) * NUM_W'(1256);
                den_sel = DEN_W'(psq_reg) * DEN_W'(100);
            end
        endcase
    end

    assign rem_sh = {drem_reg[NUM_W-2:0], dnum_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= '0;
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg + QUO_CNT_W'(1);
            if (dcnt_reg == QUO_CNT_W'(NUM_W - 1))
            begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    logic [6:0] dstep_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            // compactness numerator carries 2^20 scaling
            dnum_reg  <= (cmd.div_sel == DIV_C) ? (num_sel << 20) : num_sel;
            dden_reg  <= den_sel;
            drem_reg  <= '0;
            dquo_reg  <= '0;
            dstep_reg <= '0;
            dsel_reg  <= cmd.div_sel;
        end
        else if (dbusy_reg)
        begin
            dstep_reg <= dstep_reg + 7'd1;
            dnum_reg  <= {dnum_reg[NUM_W-2:0], 1'b0};
            if (rem_sh >= dden_reg)
            begin
                drem_reg <= rem_sh - dden_reg;
                dquo_reg <= {dquo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= rem_sh;
                dquo_reg <= {dquo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    logic div_done;
    assign div_done     = dbusy_reg && (dstep_reg == 7'(NUM_W - 1));
    assign sts.div_done = div_done;

    // Final quotient bit, combined
    logic [QUO_W-1:0] quo_fin;
    assign quo_fin = {dquo_reg[QUO_W-2:0], (rem_sh >= dden_reg)};

    // Format results as each division finishes
    logic [Q_W-1:0] res_x_reg;
    logic [Q_W-1:0] res_y_reg;
    logic [Q_W-1:0] res_c_reg;
    logic [QUO_W:0] cx_sum;
    logic [QUO_W:0] cy_sum;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;

    assign qx     = (a_reg == '0) ? '0 : quo_fin;
    assign qy     = qx;
    assign cx_sum = (QUO_W + 1)'({roi_x_reg, 4'b1000}) + (QUO_W + 1)'(qx);
    assign cy_sum = (QUO_W + 1)'({roi_y_reg, 4'b1000}) + (QUO_W + 1)'(qy);

    // Route the finished quotient by the divide that is running
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (dsel_reg)
                DIV_X:
                begin
                    res_x_reg <= (cx_sum > (QUO_W + 1)'(65535)) ? '1 : cx_sum[Q_W-1:0];
                end
                DIV_Y:
                begin
                    res_y_reg <= (cy_sum > (QUO_W + 1)'(65535)) ? '1 : cy_sum[Q_W-1:0];
                end
                default:
                begin
                    if (per_reg == '0)
                    begin
                        res_c_reg <= (a_reg != '0) ? '1 : '0;
                    end
                    else
                    begin
                        res_c_reg <= (quo_fin > QUO_W'(65535)) ? '1 : quo_fin[Q_W-1:0];
                    end
                end
            endcase
        end
    end

    // Shift pointer: start at n, move entries down one per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            sh_reg <= n_reg;
        end
        else if (cmd.shift_step)
        begin
            sh_reg <= sh_reg - CNT_W'(1);
        end
    end

    // List update
    always_ff @(posedge clk)
    begin
        if (cmd.shift_step)
        begin
            kept_area[sh_idx]  <= kept_area[IDX_W'(sh_reg - CNT_W'(1))];
            kept_x[sh_idx]     <= kept_x[IDX_W'(sh_reg - CNT_W'(1))];
            kept_y[sh_idx]     <= kept_y[IDX_W'(sh_reg - CNT_W'(1))];
            kept_shape[sh_idx] <= kept_shape[IDX_W'(sh_reg - CNT_W'(1))];
        end
        else if (cmd.write_ent)
        begin
            kept_area[pos_idx]  <= a_reg;
            kept_x[pos_idx]     <= res_x_reg;
            kept_y[pos_idx]     <= res_y_reg;
            kept_shape[pos_idx] <= res_c_reg;
        end
    end

    // Emit pointer and count
    logic [CNT_W-1:0] eptr_reg;
    logic [IDX_W-1:0] e_idx;
    assign e_idx         = eptr_reg[IDX_W-1:0];
    assign sts.emit_last = (eptr_reg + CNT_W'(1) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            eptr_reg  <= '0;
        end
        else
        begin
            if (cmd.emit_clr)
            begin
                eptr_reg <= '0;
            end
            else if (cmd.emit_step)
            begin
                eptr_reg <= eptr_reg + CNT_W'(1);
            end
            if (cmd.write_ent)
            begin
                count_reg <= n_reg + CNT_W'(1);
            end
            else if ((cmd.emit_step && sts.emit_last) || cmd.emit_empty)
            begin
                count_reg <= '0;
            end
        end
    end

    // Output word register
    logic strobe_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_step || cmd.emit_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            valid_res       <= 1'b1;
            area_out        <= kept_area[e_idx];
            centroid_x_q4   <= kept_x[e_idx];
            centroid_y_q4   <= kept_y[e_idx];
            compactness_q12 <= kept_shape[e_idx];
            last            <= sts.emit_last;
        end
        else if (cmd.emit_empty)
        begin
            valid_res       <= 1'b0;
            area_out        <= '0;
            centroid_x_q4   <= '0;
            centroid_y_q4   <= '0;
            compactness_q12 <= '0;
            last            <= 1'b1;
        end
    end

    assign strobe = strobe_reg;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTICLES))
        else $error("list count above capacity");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_step && sts.emit_last) |=> (count_reg == '0))
        else $error("list not cleared after last word");
    a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !dbusy_reg || div_done)
        else $error("divider restarted while busy");
`endif

endmodule

/* sv/blob_top_k_area_selector_core.sv */
// ----------------------------------------------------------------------------
// Blob top-k area selector
// Keeps the largest blobs of a frame and emits them sorted at end of frame.
// ----------------------------------------------------------------------------
// A blob word is filtered, searched for its place, divided three times by
// the serial divider, shifted in and written. An end-of-frame word emits
// one result per cycle, or one empty word with valid_res low if the list
// is empty; results carry a one-cycle strobe and cannot be stalled.
// Reset is asynchronous, active low; the list is empty after reset.
module blob_top_k_area_selector_core
    import btk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  action,
    input  logic [AREA_W-1:0]     blob_area,
    input  logic [MOM_W-1:0]      moment_x,
    input  logic [MOM_W-1:0]      moment_y,
    input  logic [PER_W-1:0]      perimeter_q4,
    output logic                  strobe,
    output logic                  valid_res,
    output logic [AREA_W-1:0]     area_out,
    output logic [Q_W-1:0]        centroid_x_q4,
    output logic [Q_W-1:0]        centroid_y_q4,
    output logic [Q_W-1:0]        compactness_q12,
    output logic                  last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    btk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    btk_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .action          (action),
        .blob_area       (blob_area),
        .moment_x        (moment_x),
        .moment_y        (moment_y),
        .perimeter_q4    (perimeter_q4),
        .strobe          (strobe),
        .valid_res       (valid_res),
        .area_out        (area_out),
        .centroid_x_q4   (centroid_x_q4),
        .centroid_y_q4   (centroid_y_q4),
        .compactness_q12 (compactness_q12),
        .last            (last)
    );

endmodule
